>>> rtl/core/i2a_pkg.sv
`timescale 1ns / 1ps
// i2a_pkg: shared types, constants and helpers for the integer to ascii block
// depends on nothing; used by every module under rtl/core
package i2a_pkg;

	localparam int NUMBER_WIDTH = 32;
	localparam int BASE_W       = 6;
	localparam int CHAR_W       = 7;
	localparam int BIT_CNT_W    = $clog2(NUMBER_WIDTH);
	localparam int DIG_CNT_W    = $clog2(NUMBER_WIDTH + 1);
	localparam int DIG_IDX_W    = $clog2(NUMBER_WIDTH);

	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(8'h61 - 8'd10);
	localparam logic [CHAR_W-1:0] CHAR_MINUS  = CHAR_W'(8'h2d);

	localparam logic MODE_UNSIGNED = 1'b0;
	localparam logic MODE_SIGNED   = 1'b1;

	// one accepted input item
	typedef struct packed {
		logic                    mode;
		logic [NUMBER_WIDTH-1:0] number;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} out_item_t;

	// classified work handed from front to back
	typedef struct packed {
		logic                    neg;
		logic [BASE_W-1:0]       base;
		logic [NUMBER_WIDTH-1:0] mag;
	} work_t;

	// digit value to ascii, lower-case letters from ten up
	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = CHAR_W'(d);
		if (d < BASE_DEC) begin
			digit_char = CHAR_ZERO + dw;
		end else begin
			digit_char = CHAR_LETTER + dw;
		end
	endfunction

endpackage

>>> rtl/core/i2a_front.sv
`timescale 1ns / 1ps
// i2a_front: classifies an input item into sign, base and magnitude
// depends on i2a_pkg
module i2a_front (
	input  i2a_pkg::in_item_t          in_item,
	input  logic [i2a_pkg::BASE_W-1:0] digit_base,
	output i2a_pkg::work_t             work
);

	logic [i2a_pkg::BASE_W-1:0] base_eff;
	logic                       is_neg;

	// clamp the configured base into the legal range
	always_comb begin
		priority if (digit_base < i2a_pkg::BASE_MIN) begin
			base_eff = i2a_pkg::BASE_MIN;
		end else if (digit_base > i2a_pkg::BASE_MAX) begin
			base_eff = i2a_pkg::BASE_MAX;
		end else begin
			base_eff = digit_base;
		end
	end

	assign is_neg = (in_item.mode == i2a_pkg::MODE_SIGNED)
		&& in_item.number[i2a_pkg::NUMBER_WIDTH-1];

	// signed mode is always decimal; negative values give their magnitude
	always_comb begin
		work.neg  = is_neg;
		work.base = (in_item.mode == i2a_pkg::MODE_SIGNED) ? i2a_pkg::BASE_DEC : base_eff;
		work.mag  = is_neg ? (~in_item.number + i2a_pkg::NUMBER_WIDTH'(1)) : in_item.number;
	end

endmodule

>>> rtl/core/i2a_queue.sv
`timescale 1ns / 1ps
// i2a_queue: two-entry queue of classified work between front and back
// depends on i2a_pkg
module i2a_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  i2a_pkg::work_t wdata,
	output logic           full,
	input  logic           pop,
	output i2a_pkg::work_t rdata,
	output logic           empty
);

	i2a_pkg::work_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> rtl/core/i2a_back.sv
`timescale 1ns / 1ps
// i2a_back: digit extraction by a bit-serial divider, digit stack and output slot
// depends on i2a_pkg
module i2a_back (
	input  logic               clk,
	input  logic               arst_n,
	input  i2a_pkg::work_t     work,
	input  logic               work_empty,
	output logic               work_pop,
	output i2a_pkg::out_item_t out_item,
	output logic               empty,
	input  logic               pop
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                              state_q;
	logic                                neg_q;
	logic [i2a_pkg::BASE_W-1:0]          base_q;
	logic [i2a_pkg::NUMBER_WIDTH-1:0]    quot_q;
	logic [i2a_pkg::BASE_W-1:0]          rem_q;
	logic [i2a_pkg::BIT_CNT_W-1:0]       bit_q;
	logic [i2a_pkg::DIG_CNT_W-1:0]       ndig_q;
	logic [i2a_pkg::BASE_W-1:0]          stack_q [i2a_pkg::NUMBER_WIDTH];
	i2a_pkg::out_item_t                  out_q;
	logic                                out_valid_q;

	logic [i2a_pkg::BASE_W:0]            trial;
	logic                                ge;
	logic [i2a_pkg::BASE_W-1:0]          rem_n;
	logic [i2a_pkg::NUMBER_WIDTH-1:0]    quot_n;
	logic                                div_done;
	logic                                slot_free;
	logic [i2a_pkg::DIG_CNT_W-1:0]       ndig_m1;
	logic [i2a_pkg::BASE_W-1:0]          top_digit;

	// one restoring division step per cycle
	always_comb begin
		trial  = {rem_q, quot_q[i2a_pkg::NUMBER_WIDTH-1]};
		ge     = (trial >= {1'b0, base_q});
		rem_n  = ge ? i2a_pkg::BASE_W'(trial - {1'b0, base_q}) : i2a_pkg::BASE_W'(trial);
		quot_n = {quot_q[i2a_pkg::NUMBER_WIDTH-2:0], ge};
	end

	assign div_done  = (bit_q == i2a_pkg::BIT_CNT_W'(i2a_pkg::NUMBER_WIDTH - 1));
	assign slot_free = !out_valid_q || pop;
	assign ndig_m1   = ndig_q - i2a_pkg::DIG_CNT_W'(1);
	assign top_digit = stack_q[ndig_m1[i2a_pkg::DIG_IDX_W-1:0]];
	assign work_pop  = (state_q == ST_IDLE) && !work_empty;

	assign out_item = out_q;
	assign empty    = !out_valid_q;

	// digit stack, filled least significant digit first
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			stack_q[ndig_q[i2a_pkg::DIG_IDX_W-1:0]] <= rem_n;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				base_q <= work.base;
				quot_q <= work.mag;
				rem_q  <= '0;
			end
			ST_DIV: begin
				quot_q <= quot_n;
				rem_q  <= div_done ? '0 : rem_n;
			end
			ST_EMIT: begin
				if (slot_free) begin
					if (neg_q) begin
						out_q.character <= i2a_pkg::CHAR_MINUS;
						out_q.last      <= 1'b0;
					end else begin
						out_q.character <= i2a_pkg::digit_char(top_digit);
						out_q.last      <= (ndig_q == i2a_pkg::DIG_CNT_W'(1));
					end
				end
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	// sequencer and output slot control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			bit_q       <= '0;
			ndig_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output slot fills on an emit and drains on a pop
			out_valid_q <= ((state_q == ST_EMIT) && slot_free) || (out_valid_q && !pop);
			unique case (state_q)
				ST_IDLE: begin
					if (!work_empty) begin
						neg_q   <= work.neg;
						bit_q   <= '0;
						ndig_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					bit_q <= div_done ? '0 : bit_q + i2a_pkg::BIT_CNT_W'(1);
					if (div_done) begin
						ndig_q <= ndig_q + i2a_pkg::DIG_CNT_W'(1);
						if (quot_n == '0) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else begin
							ndig_q <= ndig_m1;
							if (ndig_q == i2a_pkg::DIG_CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/integer_to_ascii_digits_top.sv
`timescale 1ns / 1ps
// Integer to ascii converter: a 32-bit number goes in, one ascii character per
// result item comes out, most significant digit first, the final one flagged
// by last. Unsigned mode uses the base in digit_base (clamped to 2..36),
// signed mode is always decimal with a leading '-' for negative values. The
// front classifies an item and hands it through a two-entry queue, so two more
// items can be taken while one converts. Each digit costs one pass of the
// bit-serial divider and one emit to the output slot, once the item is taken
// from the queue; a minus sign adds one more emit, and a stalled output holds
// the emits back.
// depends on i2a_pkg, i2a_front, i2a_queue, i2a_back
module integer_to_ascii_digits_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  i2a_pkg::in_item_t          in_item,
	output logic                       empty,
	input  logic                       pop,
	output i2a_pkg::out_item_t         out_item,
	input  logic                       cfg_we,
	input  logic [i2a_pkg::BASE_W-1:0] cfg_wdata
);

	logic [i2a_pkg::BASE_W-1:0] digit_base_q;
	i2a_pkg::work_t             front_work;
	i2a_pkg::work_t             queue_work;
	logic                       queue_empty;
	logic                       queue_pop;

	// base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_base_q <= i2a_pkg::BASE_RESET;
		end else if (cfg_we) begin
			digit_base_q <= cfg_wdata;
		end
	end

	i2a_front u_front (
		.in_item    (in_item),
		.digit_base (digit_base_q),
		.work       (front_work)
	);

	i2a_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_work),
		.full   (full),
		.pop    (queue_pop),
		.rdata  (queue_work),
		.empty  (queue_empty)
	);

	i2a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (queue_work),
		.work_empty (queue_empty),
		.work_pop   (queue_pop),
		.out_item   (out_item),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

>>> tb/tb_integer_to_ascii_digits_top.sv
`timescale 1ns / 1ps
// tb_integer_to_ascii_digits_top: self-checking bench for integer_to_ascii_digits_top
// depends on i2a_pkg and the rtl top; predicts every character and checks it in order
module tb_integer_to_ascii_digits_top;

	localparam int DRAIN_GAP  = 40;
	localparam int TAIL_GAP   = 100;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 42;

	// expected characters of every accepted number, oldest first
	class ascii_scoreboard;
		i2a_pkg::out_item_t         expected_chars[$];
		logic [i2a_pkg::BASE_W-1:0] digit_base;
		int                         errors;
		string                      numerals;

		function new();
			digit_base = i2a_pkg::BASE_RESET;
			errors = 0;
			numerals = "0123456789abcdefghijklmnopqrstuvwxyz";
		endfunction

		function void set_base(logic [i2a_pkg::BASE_W-1:0] value);
			digit_base = value;
		endfunction

		// spell out one accepted number as the characters it should produce
		function void note_number(i2a_pkg::in_item_t item);
			logic [i2a_pkg::NUMBER_WIDTH-1:0] mag;
			logic [i2a_pkg::NUMBER_WIDTH-1:0] radix;
			int                               digits[$];
			i2a_pkg::out_item_t               ch;
			mag = item.number;
			if (item.mode == i2a_pkg::MODE_SIGNED) begin
				radix = i2a_pkg::NUMBER_WIDTH'(i2a_pkg::BASE_DEC);
				if (mag[i2a_pkg::NUMBER_WIDTH-1]) begin
					mag = -mag;
					ch.character = i2a_pkg::CHAR_MINUS;
					ch.last = 1'b0;
					expected_chars.push_back(ch);
				end
			end else if (digit_base < i2a_pkg::BASE_MIN) begin
				radix = i2a_pkg::NUMBER_WIDTH'(i2a_pkg::BASE_MIN);
			end else if (digit_base > i2a_pkg::BASE_MAX) begin
				radix = i2a_pkg::NUMBER_WIDTH'(i2a_pkg::BASE_MAX);
			end else begin
				radix = i2a_pkg::NUMBER_WIDTH'(digit_base);
			end
			// least significant digit first, so build the list from the front
			do begin
				digits.push_front(int'(mag % radix));
				mag = mag / radix;
			end while (mag != 0);
			for (int i = 0; i < digits.size(); i++) begin
				ch.character = i2a_pkg::CHAR_W'(numerals[digits[i]]);
				ch.last = (i == digits.size() - 1);
				expected_chars.push_back(ch);
			end
		endfunction

		// compare one popped character with the oldest expectation
		function void check_char(i2a_pkg::out_item_t got);
			i2a_pkg::out_item_t want;
			if (expected_chars.size() == 0) begin
				$error("character: expected none, actual %0h", got.character);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			if (got.character !== want.character) begin
				$error("character: expected %0h, actual %0h", want.character, got.character);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	i2a_pkg::in_item_t          in_item;
	logic                       empty;
	logic                       pop;
	i2a_pkg::out_item_t         out_item;
	logic                       cfg_we;
	logic [i2a_pkg::BASE_W-1:0] cfg_wdata;

	ascii_scoreboard board;
	int              send_idle_pct;
	int              stall_pct;

	integer_to_ascii_digits_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50_000_000;
		$display("FAILURE");
		$finish;
	end

	// result side: pop with random stalls and check every accepted character
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				board.check_char(out_item);
			end
			pop <= !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
		end
	end

	// offer one number, with random idle cycles first, until it is taken
	task automatic send_item(input logic mode,
			input logic [i2a_pkg::NUMBER_WIDTH-1:0] number);
		i2a_pkg::in_item_t item;
		item.mode = mode;
		item.number = number;
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_item <= item;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		board.note_number(item);
	endtask

	// let every expected character come out, then give the block a moment
	task automatic wait_drained();
		push <= 1'b0;
		while (board.expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_base(input logic [i2a_pkg::BASE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_base(value);
	endtask

	// includes out-of-range bases that must clamp to 2 or 36
	function automatic logic [i2a_pkg::BASE_W-1:0] base_for_phase(input int p);
		case (p)
			0: base_for_phase = i2a_pkg::BASE_DEC;
			1: base_for_phase = i2a_pkg::BASE_MIN;
			2: base_for_phase = i2a_pkg::BASE_MAX;
			3: base_for_phase = i2a_pkg::BASE_W'(16);
			4: base_for_phase = i2a_pkg::BASE_W'(0);
			5: base_for_phase = i2a_pkg::BASE_W'(63);
			6: base_for_phase = i2a_pkg::BASE_W'(37);
			7: base_for_phase = i2a_pkg::BASE_W'(1);
			8: base_for_phase = i2a_pkg::BASE_W'(8);
			default: base_for_phase = i2a_pkg::BASE_W'(3);
		endcase
	endfunction

	// mix of full-range, small, power-of-two and near-extreme numbers
	function automatic logic [i2a_pkg::NUMBER_WIDTH-1:0] pick_number();
		logic [i2a_pkg::NUMBER_WIDTH-1:0] one;
		one = 1;
		case ($urandom_range(0, 5))
			0, 1: pick_number = $urandom;
			2: pick_number = $urandom_range(0, 40);
			3: pick_number = one << $urandom_range(0, i2a_pkg::NUMBER_WIDTH - 1);
			4: pick_number = (one << $urandom_range(0, i2a_pkg::NUMBER_WIDTH - 1)) - 1;
			default: pick_number = {1'b1, {(i2a_pkg::NUMBER_WIDTH-1){1'b0}}}
				^ $urandom_range(0, 40);
		endcase
	endfunction

	// stimulus
	initial begin
		board = new();
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed numbers in the reset base, decimal
		send_item(i2a_pkg::MODE_UNSIGNED, 32'd0);
		send_item(i2a_pkg::MODE_UNSIGNED, 32'd1);
		send_item(i2a_pkg::MODE_UNSIGNED, 32'd9);
		send_item(i2a_pkg::MODE_UNSIGNED, 32'd10);
		send_item(i2a_pkg::MODE_UNSIGNED, 32'd99);
		send_item(i2a_pkg::MODE_UNSIGNED, 32'd100);
		send_item(i2a_pkg::MODE_UNSIGNED, 32'hFFFF_FFFF);
		send_item(i2a_pkg::MODE_UNSIGNED, 32'h8000_0000);
		send_item(i2a_pkg::MODE_UNSIGNED, 32'd1_000_000_000);
		send_item(i2a_pkg::MODE_SIGNED, 32'd0);
		send_item(i2a_pkg::MODE_SIGNED, 32'd1);
		send_item(i2a_pkg::MODE_SIGNED, 32'hFFFF_FFFF);
		send_item(i2a_pkg::MODE_SIGNED, 32'hFFFF_FFF6);
		send_item(i2a_pkg::MODE_SIGNED, 32'hFFFF_FFF7);
		send_item(i2a_pkg::MODE_SIGNED, 32'h7FFF_FFFF);
		// most negative value has no positive twin
		send_item(i2a_pkg::MODE_SIGNED, 32'h8000_0000);
		send_item(i2a_pkg::MODE_SIGNED, 32'h8000_0001);

		// random phases, each with its own base and idle pattern
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_base(base_for_phase(p));
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 45; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 45; end
				default: begin send_idle_pct = 33; stall_pct = 33; end
			endcase
			send_item(i2a_pkg::MODE_UNSIGNED, '0);
			send_item(i2a_pkg::MODE_UNSIGNED, '1);
			repeat (PHASE_ITEMS) send_item(1'($urandom_range(0, 1)), pick_number());
		end

		// drain and watch for stray characters
		push <= 1'b0;
		while (board.expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_GAP) @(posedge clk);
		if (board.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
